// ----- sv/fexp_pkg.sv -----
// shared types, constants and binary32 arithmetic helpers for the exponential pipeline
package fexp_pkg;

    // special-case codes that travel with each transaction
    localparam logic [1:0] SPEC_NONE = 2'd0;
    localparam logic [1:0] SPEC_NAN  = 2'd1;
    localparam logic [1:0] SPEC_ZERO = 2'd2;
    localparam logic [1:0] SPEC_INF  = 2'd3;

    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
    localparam logic [31:0] PINF_BITS = 32'h7f80_0000;
    localparam logic [30:0] MAG_87    = 31'h42ae_0000;
    localparam logic [30:0] MAG_88    = 31'h42b0_0000;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;

    localparam logic [31:0] LOG2E = 32'h3fb8_aa3b;
    localparam logic [31:0] C4    = 32'h3c60_1977;
    localparam logic [31:0] C3    = 32'h3d54_0bf2;
    localparam logic [31:0] C2    = 32'h3e77_2e94;
    localparam logic [31:0] C1    = 32'h3f31_6a93;
    localparam logic [31:0] C0    = 32'h3f80_0000;

    localparam int unsigned NSTEP = 4;
    localparam logic [31:0] COEF [NSTEP] = '{C3, C2, C1, C0};

    // side data carried alongside the arithmetic
    typedef struct packed {
        logic [1:0]  spec;
        logic [7:0]  scale_exp;
        logic [31:0] f;
    } tag_t;

    // unrounded result: value = m / 2^47 * 2^(e - 127)
    typedef struct packed {
        logic               sign;
        logic signed [10:0] e;
        logic [47:0]        m;
    } fp_raw_t;

    function automatic fp_raw_t fp_mul_raw(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        fp_raw_t     r;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        r.sign = a[31] ^ b[31];
        r.e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
        r.m = ma * mb;
        return r;
    endfunction

    function automatic fp_raw_t fp_add_raw(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [23:0] mbg;
        logic [23:0] msm;
        logic [26:0] ext;
        logic [26:0] shf;
        logic [26:0] mask;
        logic [26:0] al;
        logic        stk;
        logic [27:0] sum;
        fp_raw_t     r;
        mask = '0;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbg = {|big[30:23], big[22:0]};
        msm = {|sml[30:23], sml[22:0]};
        d   = eb - es;
        ext = {msm, 3'b000};
        if (d >= 8'd27)
        begin
            shf = '0;
            stk = |ext;
        end
        else
        begin
            shf  = ext >> d;
            mask = ~({27{1'b1}} << d);
            stk  = |(ext & mask);
        end
        // guard, round and sticky sit in the low three bits
        al = {shf[26:1], shf[0] | stk};
        if (big[31] == sml[31])
            sum = {1'b0, mbg, 3'b000} + {1'b0, al};
        else
            sum = {1'b0, mbg, 3'b000} - {1'b0, al};
        r.sign = (sum == 28'd0) ? (a[31] & b[31]) : big[31];
        r.e    = $signed({3'b000, eb}) + 11'sd1;
        r.m    = {sum, 20'd0};
        return r;
    endfunction

    // normalise, handle gradual underflow, round to nearest even
    function automatic logic [31:0] fp_round(input fp_raw_t r);
        logic [5:0]         lz;
        logic               found;
        logic [47:0]        mn;
        logic [47:0]        ms;
        logic signed [10:0] en;
        logic signed [10:0] sh;
        logic               lost;
        logic [7:0]         efield;
        logic [23:0]        keep;
        logic               g;
        logic               st;
        logic               inc;
        logic [30:0]        mag;
        lz    = '0;
        found = 1'b0;
        lost  = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && r.m[i])
            begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        mn = r.m << lz;
        en = r.e - $signed({5'b00000, lz});
        if (en < 11'sd1)
        begin
            sh     = 11'sd1 - en;
            efield = 8'd0;
            if (sh >= 11'sd48)
            begin
                ms   = '0;
                lost = |mn;
            end
            else
            begin
                ms   = mn >> sh[5:0];
                lost = |(mn & ~({48{1'b1}} << sh[5:0]));
            end
        end
        else
        begin
            ms     = mn;
            efield = en[7:0];
        end
        keep = ms[47:24];
        g    = ms[23];
        st   = (|ms[22:0]) | lost;
        inc  = g & (st | keep[0]);
        mag  = {efield, keep[22:0]} + {30'd0, inc};
        if (!found)
            return {r.sign, 31'd0};
        return {r.sign, mag};
    endfunction

endpackage

// ----- sv/fexp_mul.sv -----
// two-stage binary32 multiplier: product stage, then normalise and round stage
module fexp_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  fexp_pkg::tag_t    in_tag,
    output logic              out_valid,
    output logic [31:0]       y,
    output fexp_pkg::tag_t    out_tag
);

    logic              v1_reg;
    logic              v2_reg;
    fexp_pkg::fp_raw_t raw_reg;
    fexp_pkg::tag_t    t1_reg;
    fexp_pkg::tag_t    t2_reg;
    logic [31:0]       y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg <= fexp_pkg::fp_mul_raw(a, b);
            t1_reg  <= in_tag;
            y_reg   <= fexp_pkg::fp_round(raw_reg);
            t2_reg  <= t1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign y         = y_reg;
    assign out_tag   = t2_reg;

endmodule

// ----- sv/fexp_add.sv -----
// two-stage binary32 adder: align and add stage, then normalise and round stage
module fexp_add (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  fexp_pkg::tag_t    in_tag,
    output logic              out_valid,
    output logic [31:0]       y,
    output fexp_pkg::tag_t    out_tag
);

    logic              v1_reg;
    logic              v2_reg;
    fexp_pkg::fp_raw_t raw_reg;
    fexp_pkg::tag_t    t1_reg;
    fexp_pkg::tag_t    t2_reg;
    logic [31:0]       y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg <= fexp_pkg::fp_add_raw(a, b);
            t1_reg  <= in_tag;
            y_reg   <= fexp_pkg::fp_round(raw_reg);
            t2_reg  <= t1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign y         = y_reg;
    assign out_tag   = t2_reg;

endmodule

// ----- sv/fexp_split.sv -----
// floor stage: splits y into integer k, gives -k as binary32 and the scale exponent k+127
module fexp_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       y,
    input  fexp_pkg::tag_t    in_tag,
    output logic              out_valid,
    output logic [31:0]       y_out,
    output logic [31:0]       negk,
    output fexp_pkg::tag_t    out_tag
);

    logic           v_reg;
    logic [31:0]    y_reg;
    logic [31:0]    negk_reg;
    fexp_pkg::tag_t t_reg;

    logic [7:0]     ex;
    logic [23:0]    mant;
    logic [7:0]     sh;
    logic [23:0]    ip_full;
    logic           fnz;
    logic           neg;
    logic [7:0]     kmag;
    logic [7:0]     scale_exp;
    logic [2:0]     lz;
    logic           found;
    logic [7:0]     kn;
    logic [31:0]    negk_next;
    fexp_pkg::tag_t tag_next;

    always_comb
    begin
        ex      = y[30:23];
        mant    = {1'b1, y[22:0]};
        neg     = y[31] && (y[30:0] != 31'd0);
        sh      = 8'd150 - ex;
        ip_full = '0;
        fnz     = 1'b0;
        if (ex < fexp_pkg::EXP_BIAS)
        begin
            fnz = (y[30:0] != 31'd0);
        end
        else if (sh >= 8'd24)
        begin
            fnz = 1'b1;
        end
        else
        begin
            ip_full = mant >> sh[4:0];
            fnz     = |(mant & ~({24{1'b1}} << sh[4:0]));
        end
        // floor rounds a negative value with a fraction one further down
        if (neg)
            kmag = ip_full[7:0] + {7'd0, fnz};
        else
            kmag = ip_full[7:0];
        scale_exp = neg ? (fexp_pkg::EXP_BIAS - kmag) : (fexp_pkg::EXP_BIAS + kmag);

        lz    = '0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!found && kmag[i])
            begin
                lz    = 3'(7 - i);
                found = 1'b1;
            end
        end
        kn = kmag << lz;
        if (!found)
            negk_next = {1'b1, 31'd0};
        else
            negk_next = {!neg, fexp_pkg::EXP_BIAS + 8'd7 - {5'd0, lz}, kn[6:0], 16'd0};

        tag_next           = in_tag;
        tag_next.scale_exp = scale_exp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y;
            negk_reg <= negk_next;
            t_reg    <= tag_next;
        end
    end

    assign out_valid = v_reg;
    assign y_out     = y_reg;
    assign negk      = negk_reg;
    assign out_tag   = t_reg;

endmodule

// ----- sv/float_exp_approx.sv -----
// single-precision exp(x) through x*log2(e), floor split, degree-4 polynomial and exponent scaling
// throughput: one transaction per cycle while the output is not held;
// each multiply and add is a two-stage unit in the chain
// a held output stalls the whole chain at once, so nothing is dropped or repeated
// reset clears every valid bit; payload registers are not reset
// nan returns quiet nan, x below -87 returns +0, x above 88 returns +inf
module float_exp_approx (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] x_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);

    localparam int unsigned NSTEP = fexp_pkg::NSTEP;

    logic           en;
    logic           out_valid_reg;
    logic [31:0]    result_reg;
    fexp_pkg::tag_t in_tag;

    logic           ym_valid;
    logic [31:0]    ym;
    fexp_pkg::tag_t ym_tag;

    logic           sp_valid;
    logic [31:0]    sp_y;
    logic [31:0]    sp_negk;
    fexp_pkg::tag_t sp_tag;

    logic           f_valid;
    logic [31:0]    f_val;
    fexp_pkg::tag_t f_tag;
    fexp_pkg::tag_t f_tag_full;

    logic           p_valid [NSTEP+1];
    logic [31:0]    p_val   [NSTEP+1];
    fexp_pkg::tag_t p_tag   [NSTEP+1];

    logic           q_valid [NSTEP];
    logic [31:0]    q_val   [NSTEP];
    fexp_pkg::tag_t q_tag   [NSTEP];

    logic           s_valid;
    logic [31:0]    s_val;
    fexp_pkg::tag_t s_tag;
    logic [31:0]    scale_bits;
    logic [31:0]    result_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        in_tag           = '0;
        in_tag.spec      = fexp_pkg::SPEC_NONE;
        if (x_bits[30:0] > fexp_pkg::PINF_BITS[30:0])
            in_tag.spec = fexp_pkg::SPEC_NAN;
        else if (x_bits[31] && (x_bits[30:0] > fexp_pkg::MAG_87))
            in_tag.spec = fexp_pkg::SPEC_ZERO;
        else if (!x_bits[31] && (x_bits[30:0] > fexp_pkg::MAG_88))
            in_tag.spec = fexp_pkg::SPEC_INF;
    end

    fexp_mul u_mul_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a         (x_bits),
        .b         (fexp_pkg::LOG2E),
        .in_tag    (in_tag),
        .out_valid (ym_valid),
        .y         (ym),
        .out_tag   (ym_tag)
    );

    fexp_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ym_valid),
        .y         (ym),
        .in_tag    (ym_tag),
        .out_valid (sp_valid),
        .y_out     (sp_y),
        .negk      (sp_negk),
        .out_tag   (sp_tag)
    );

    fexp_add u_add_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sp_valid),
        .a         (sp_y),
        .b         (sp_negk),
        .in_tag    (sp_tag),
        .out_valid (f_valid),
        .y         (f_val),
        .out_tag   (f_tag)
    );

    // the fraction rides in the tag so every horner step can reach it
    always_comb
    begin
        f_tag_full   = f_tag;
        f_tag_full.f = f_val;
    end

    assign p_valid[0] = f_valid;
    assign p_val[0]   = fexp_pkg::C4;
    assign p_tag[0]   = f_tag_full;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_horner
        fexp_mul u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (p_valid[i]),
            .a         (p_val[i]),
            .b         (p_tag[i].f),
            .in_tag    (p_tag[i]),
            .out_valid (q_valid[i]),
            .y         (q_val[i]),
            .out_tag   (q_tag[i])
        );

        fexp_add u_add (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (q_valid[i]),
            .a         (q_val[i]),
            .b         (fexp_pkg::COEF[i]),
            .in_tag    (q_tag[i]),
            .out_valid (p_valid[i+1]),
            .y         (p_val[i+1]),
            .out_tag   (p_tag[i+1])
        );
    end

    // 2^k built straight in the exponent field
    assign scale_bits = {1'b0, p_tag[NSTEP].scale_exp, 23'd0};

    fexp_mul u_mul_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid[NSTEP]),
        .a         (p_val[NSTEP]),
        .b         (scale_bits),
        .in_tag    (p_tag[NSTEP]),
        .out_valid (s_valid),
        .y         (s_val),
        .out_tag   (s_tag)
    );

    always_comb
    begin
        case (s_tag.spec)
            fexp_pkg::SPEC_NAN:  result_next = fexp_pkg::QNAN_BITS;
            fexp_pkg::SPEC_ZERO: result_next = 32'd0;
            fexp_pkg::SPEC_INF:  result_next = fexp_pkg::PINF_BITS;
            default:             result_next = s_val;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

endmodule

// ----- sv/fexp_checker.sv -----
// port-level checker for the exponential pipeline and its bind to the top level
module fexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_bits
);

    // the input side only backs up when a result is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("held output transaction changed");

    // exp never gives a negative value, not even -0
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !result_bits[31])
        else $error("negative result");

    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_bits[30:23] == 8'hff) && (result_bits[22:0] != 23'd0)
        |-> result_bits == 32'h7fc0_0000)
        else $error("non-canonical nan on the output");

    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall && (in_valid || !in_valid))
        else $error("output valid right after reset");

endmodule

bind float_exp_approx fexp_checker u_fexp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_bits (result_bits)
);

// ----- dv/testbench.sv -----
// self-checking testbench for the single-precision exponential pipeline
module testbench;

    localparam int N_RANDOM  = 680;
    localparam int MAX_SHOWN = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] x_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;

    float_exp_approx u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_bits      (x_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_bits (result_bits)
    );

    // round the exact value m * 2^e to binary32, nearest-even
    function automatic logic [31:0] round_to_single(input logic s, input logic [63:0] m,
                                                    input int e);
        int          p;
        int          be;
        int          sh;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] r;
        p = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
                p = i;
        end
        if (p < 0)
            return {s, 31'd0};
        be = p + e + 127;
        sh = (be >= 1) ? p - 23 : -149 - e;
        if (sh <= 0)
            mant = m << (-sh);
        else if (sh > 64)
            mant = '0;
        else
        begin
            mant = (sh == 64) ? 64'd0 : m >> sh;
            half = 64'd1 << (sh - 1);
            rem  = m & ((64'd1 << sh) - 64'd1);
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 64'd1;
        end
        r = (be >= 1) ? (32'(be - 1) << 23) + mant[31:0] : mant[31:0];
        if (r >= fexp_pkg::PINF_BITS)
            r = fexp_pkg::PINF_BITS;
        return {s, r[30:0]};
    endfunction

    function automatic void split_single(input logic [31:0] w, output logic s,
                                         output logic [63:0] m, output int e);
        s = w[31];
        if (w[30:23] == 8'd0)
        begin
            m = {41'd0, w[22:0]};
            e = -149;
        end
        else
        begin
            m = {40'd0, 1'b1, w[22:0]};
            e = int'(w[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sa;
        logic        sb;
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        split_single(a, sa, ma, ea);
        split_single(b, sb, mb, eb);
        return round_to_single(sa ^ sb, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
        logic        sa;
        logic        sb;
        logic        shi;
        logic        slo;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mhi;
        logic [63:0] mlo;
        logic [63:0] sum;
        int          ea;
        int          eb;
        int          ehi;
        int          elo;
        int          d;
        split_single(a, sa, ma, ea);
        split_single(b, sb, mb, eb);
        if (ma == 0 && mb == 0)
            return {sa & sb, 31'd0};
        if (ma == 0)
            return b;
        if (mb == 0)
            return a;
        if (ea >= eb)
        begin
            shi = sa; mhi = ma; ehi = ea; slo = sb; mlo = mb; elo = eb;
        end
        else
        begin
            shi = sb; mhi = mb; ehi = eb; slo = sa; mlo = ma; elo = ea;
        end
        d = ehi - elo;
        // a far smaller operand only matters as a sticky bit below the round point
        if (d > 40)
        begin
            mhi = mhi << 40;
            mlo = 64'd1;
            elo = ehi - 40;
        end
        else
            mhi = mhi << d;
        if (shi == slo)
            return round_to_single(shi, mhi + mlo, elo);
        if (mhi == mlo)
            return 32'd0;
        if (mhi > mlo)
            return round_to_single(shi, mhi - mlo, elo);
        return round_to_single(slo, mlo - mhi, elo);
    endfunction

    function automatic logic [31:0] predict_exp(input logic [31:0] x);
        logic [31:0] y;
        logic [31:0] neg_k;
        logic [31:0] f;
        logic [31:0] p;
        logic [31:0] scale;
        logic        s;
        logic [63:0] m;
        logic [63:0] whole;
        logic        frac;
        int          e;
        int          k;
        if (x[30:0] > fexp_pkg::PINF_BITS[30:0])
            return fexp_pkg::QNAN_BITS;
        if (x[31] && x[30:0] > fexp_pkg::MAG_87)
            return 32'd0;
        if (!x[31] && x[30:0] > fexp_pkg::MAG_88)
            return fexp_pkg::PINF_BITS;
        y = single_mul(x, fexp_pkg::LOG2E);
        split_single(y, s, m, e);
        if (e >= 0)
        begin
            whole = m << e;
            frac  = 1'b0;
        end
        else
        begin
            whole = (-e >= 64) ? 64'd0 : m >> (-e);
            frac  = (-e >= 64) ? (m != 0) : ((m & ((64'd1 << (-e)) - 64'd1)) != 0);
        end
        // floor: truncation moves one further down for negative non-integers
        k = s ? -int'(whole) - (frac ? 1 : 0) : int'(whole);
        neg_k = round_to_single(k >= 0, 64'(k < 0 ? -k : k), 0);
        f = single_add(y, neg_k);
        p = fexp_pkg::C4;
        for (int i = 0; i < fexp_pkg::NSTEP; i++)
            p = single_add(single_mul(p, f), fexp_pkg::COEF[i]);
        scale = {1'b0, 8'(k + 127), 23'd0};
        return single_mul(p, scale);
    endfunction

    class exp_scoreboard;
        logic [31:0] expected_q[$];
        logic [31:0] arg_q[$];
        int          mismatches = 0;
        int          matched    = 0;

        function void note_input(logic [31:0] x);
            expected_q.push_back(predict_exp(x));
            arg_q.push_back(x);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            logic [31:0] arg;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result transaction %h", got);
                return;
            end
            want = expected_q.pop_front();
            arg  = arg_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("mismatch x=%h expected=%h actual=%h", arg, want, got);
            end
            else
                matched++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    exp_scoreboard sb = new();
    int            n_sent = 0;
    int            n_special = 0;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one input transaction, held until accepted
    task automatic send_arg(input logic [31:0] v);
        in_valid <= 1'b1;
        x_bits   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(v);
        n_sent++;
        if (v[30:0] > fexp_pkg::PINF_BITS[30:0] ||
            (v[31] && v[30:0] > fexp_pkg::MAG_87) ||
            (!v[31] && v[30:0] > fexp_pkg::MAG_88))
            n_special++;
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        x_bits   <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_arg();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return {1'($urandom), 8'($urandom_range(0, 133)), 23'($urandom)};
        if (sel < 70)
            return {1'($urandom), 8'h85, 2'b01, 21'($urandom)};
        if (sel < 75)
            return {1'($urandom), 8'd0, 23'($urandom)};
        return $urandom;
    endfunction

    // receiver: stall pattern changes every so often
    int stall_mode = 0;
    int stall_left = 0;
    int cyc = 0;
    initial out_stall = 1'b0;
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_bits);
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (cyc % 5 < 2);
        endcase
    end

    initial
    begin
        logic [31:0] directed [$];
        int          burst;
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                     32'hc2ae_0000, 32'h42b0_0000, 32'hc2ae_0001, 32'h42b0_0001,
                     32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff,
                     32'h7f80_0001, 32'h0000_0001, 32'h8000_0001, 32'h007f_ffff,
                     32'h7f7f_ffff, 32'hff7f_ffff, 32'h3f31_7218, 32'hbf00_0000,
                     32'h42ad_ffff, 32'hc2ad_ffff, 32'h42af_ffff, 32'hbf31_7218};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        x_bits   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_arg(directed[i]);
        drain();
        for (int i = 0; i < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && i < N_RANDOM; j++, i++)
                send_arg(random_arg());
            if (i > N_RANDOM / 2 && i - burst <= N_RANDOM / 2)
                drain();
            else if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end
        drain();
        repeat (60) @(posedge clk);
        $display("sent %0d arguments (%0d nan or out of range), %0d results matched",
                 n_sent, n_special, sb.matched);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("status: fail");
        $finish;
    end

endmodule
